>>> rtl/rtr_pkg.sv
// Package for the rigid transform / deviation scoring block.
// Holds the sequencer states, register indexes, sizes and shared helpers.
// Depends on nothing.
package rtr_pkg;

    localparam int MAX_POINTS = 4096;
    localparam int CNT_W      = 13;
    localparam int ADDR_W     = 4;

    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_ROW   = 1'b1;

    typedef enum logic [1:0] {
        REG_MODE,
        REG_COUNT,
        REG_OFFSET,
        REG_LENGTH
    } rtr_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_ROUND,
        ST_SQ,
        ST_SQACC,
        ST_WEIGHT,
        ST_DIV,
        ST_ADDSUM,
        ST_SCORE,
        ST_SQRT,
        ST_OUT
    } rtr_state_t;

    function automatic logic [63:0] add_sat64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage

>>> rtl/rtr_if.sv
// Valid/ready channel interfaces for the rigid transform block.
// Input channel carries row loads and point pairs; output carries moved points.
// Depends on nothing.
interface rtr_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [1:0]         row_index;
    logic signed [31:0] row_coef_x;
    logic signed [31:0] row_coef_y;
    logic signed [31:0] row_coef_z;
    logic signed [31:0] translation_part;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] moved_x;
    logic signed [31:0] moved_y;
    logic signed [31:0] moved_z;

    modport source (output valid, kind, row_index, row_coef_x, row_coef_y, row_coef_z,
                    translation_part, target_x, target_y, target_z,
                    moved_x, moved_y, moved_z, input ready);
    modport sink   (input valid, kind, row_index, row_coef_x, row_coef_y, row_coef_z,
                    translation_part, target_x, target_y, target_z,
                    moved_x, moved_y, moved_z, output ready);
endinterface

interface rtr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               last_point;
    logic [39:0]        score;

    modport source (output valid, out_x, out_y, out_z, last_point, score, input ready);
    modport sink   (input valid, out_x, out_y, out_z, last_point, score, output ready);
endinterface

>>> rtl/rigid_transform_rmsd.sv
// Top level of the rigid transform / deviation scoring block.
// Uses rtr_pkg and the channel interfaces in rtr_if.sv.
//
//   channel   dir   handshake          payload
//   in_ch     in    valid/ready        row load or point pair
//   out_ch    out   valid/ready        moved point, last flag, score
//   apb       in    psel/penable/...   score_mode, point_count, offset, length
//
// A point runs the product and square steps on the shared 33x33 multiplier
// (nine products, three squares), then the bit-serial divider in weighted
// mode; the last point of a group also runs the divider and the square
// root in RMSD mode.
// Reset clears the transform, accumulator and point index, and sets the
// registers to mode 0, count 1, offset 0 and length 1.
// in_ch is ready only when the sequencer is idle; a result waiting on
// out_ch stalls the sequencer at its final step.
module rigid_transform_rmsd (
    input  logic                       clk,
    input  logic                       rst_n,
    rtr_in_if.sink                     in_ch,
    rtr_out_if.source                  out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rtr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import rtr_pkg::*;

    rtr_state_t state_reg, state_next;

    logic              mode_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [15:0]       offset_reg;
    logic [15:0]       length_reg;

    logic signed [31:0] rot_reg [9];
    logic signed [31:0] trn_reg [3];
    logic signed [31:0] tg_reg  [3];
    logic signed [31:0] pt_reg  [3];
    logic signed [31:0] mv_reg  [3];
    logic signed [31:0] mv_next [3];

    logic [1:0]  row_reg, row_next;
    logic [1:0]  col_reg, col_next;
    logic signed [65:0] prod_reg, prod_next;
    logic signed [67:0] acc_reg, acc_next;
    logic [63:0] d2_reg, d2_next;
    logic [63:0] dev_reg, dev_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic        last_reg, last_next;

    logic [63:0] num_reg, num_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] den_reg, den_next;
    logic [5:0]  step_reg, step_next;
    logic        div_score_reg, div_score_next;

    logic [63:0] sq_v_reg, sq_v_next;
    logic [63:0] sq_res_reg, sq_res_next;
    logic [63:0] sq_bit_reg, sq_bit_next;
    logic [39:0] score_reg, score_next;

    logic              ovalid_reg;
    logic              out_load;

    // shared multiplier and helpers
    logic signed [32:0] mult_a, mult_b;
    logic [3:0]         rot_idx;
    logic signed [32:0] diff;
    logic signed [67:0] rnd_sum;
    logic signed [38:0] qt;
    logic [12:0]        count_eff;
    logic signed [18:0] pos_s, cnt_s, len_s, wi_s;
    logic [16:0]        div_r;
    logic [63:0]        sq_sum;
    logic [48:0]        sc_round;
    logic               cfg_wr;
    logic               in_acc;

    assign in_acc         = in_ch.valid && in_ch.ready;
    assign in_ch.ready    = (state_reg == ST_IDLE);
    assign pready         = 1'b1;
    assign cfg_wr         = psel && penable && pwrite;
    assign out_ch.valid   = ovalid_reg;

    assign rot_idx = 4'(row_reg) * 4'd3 + 4'(col_reg);
    assign diff    = 33'(tg_reg[col_reg]) - 33'(mv_reg[col_reg]);
    assign count_eff = (count_reg == '0) ? 13'd1
                     : (count_reg > 13'(MAX_POINTS)) ? 13'(MAX_POINTS) : count_reg;

    always_comb
    begin
        case (rtr_reg_t'(paddr[3:2]))
            REG_MODE:   prdata = 32'(mode_reg);
            REG_COUNT:  prdata = 32'(count_reg);
            REG_OFFSET: prdata = 32'(offset_reg);
            REG_LENGTH: prdata = 32'(length_reg);
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_SQ)
        begin
            mult_a = diff;
            mult_b = diff;
        end
        else
        begin
            mult_a = 33'(rot_reg[rot_idx]);
            mult_b = 33'(pt_reg[col_reg]);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_acc && in_ch.kind == KIND_POINT) state_next = ST_MUL;
            ST_MUL:    state_next = ST_ACC;
            ST_ACC:    state_next = (col_reg == 2'd2) ? ST_ROUND : ST_MUL;
            ST_ROUND:  state_next = (row_reg == 2'd2) ? ST_SQ : ST_MUL;
            ST_SQ:     state_next = ST_SQACC;
            ST_SQACC:  state_next = (col_reg == 2'd2) ? ST_WEIGHT : ST_SQ;
            ST_WEIGHT: state_next = mode_reg ? ST_DIV : ST_ADDSUM;
            ST_DIV:
                if (step_reg == 6'd63)
                    state_next = div_score_reg ? ST_SQRT : ST_ADDSUM;
            ST_ADDSUM: state_next = ST_SCORE;
            ST_SCORE:  state_next = (last_reg && !mode_reg) ? ST_DIV : ST_OUT;
            ST_SQRT:   if (step_reg == 6'd31) state_next = ST_OUT;
            ST_OUT:    if (!ovalid_reg || out_ch.ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign out_load = (state_reg == ST_OUT) && (!ovalid_reg || out_ch.ready);

    // datapath
    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        d2_next        = d2_reg;
        dev_next       = dev_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        step_next      = step_reg;
        div_score_next = div_score_reg;
        sq_v_next      = sq_v_reg;
        sq_res_next    = sq_res_reg;
        sq_bit_next    = sq_bit_reg;
        score_next     = score_reg;
        for (int i = 0; i < 3; i++) mv_next[i] = mv_reg[i];

        rnd_sum  = acc_reg + 68'sd536870912;
        qt       = 39'($signed(rnd_sum[67:30])) + 39'(trn_reg[row_reg]);
        pos_s    = 19'(offset_reg) + 19'(idx_reg);
        cnt_s    = 19'(count_eff);
        len_s    = 19'(length_reg);
        wi_s     = (pos_s < cnt_s - 19'sd1) ? pos_s + 19'sd1 : cnt_s;
        if (pos_s > len_s - cnt_s) wi_s = len_s - pos_s;
        if (wi_s < 19'sd1) wi_s = 19'sd1;
        div_r    = {rem_reg, num_reg[63]};
        sq_sum   = sq_res_reg + sq_bit_reg;
        sc_round = 49'(dev_reg[63:16]) + 49'(dev_reg[15]);

        case (state_reg)
            ST_IDLE:
            begin
                row_next = '0;
                col_next = '0;
                acc_next = '0;
                d2_next  = '0;
            end
            ST_MUL, ST_SQ:
                prod_next = mult_a * mult_b;
            ST_ACC:
            begin
                acc_next = acc_reg + 68'(prod_reg);
                col_next = (col_reg == 2'd2) ? 2'd0 : col_reg + 2'd1;
            end
            ST_ROUND:
            begin
                if (qt > 39'sd2147483647)
                    mv_next[row_reg] = 32'sh7FFFFFFF;
                else if (qt < -39'sd2147483648)
                    mv_next[row_reg] = 32'sh80000000;
                else
                    mv_next[row_reg] = qt[31:0];
                acc_next = '0;
                row_next = (row_reg == 2'd2) ? 2'd0 : row_reg + 2'd1;
            end
            ST_SQACC:
            begin
                d2_next  = add_sat64(d2_reg, prod_reg[63:0]);
                col_next = (col_reg == 2'd2) ? 2'd0 : col_reg + 2'd1;
            end
            ST_WEIGHT:
            begin
                num_next       = d2_reg;
                den_next       = wi_s[15:0];
                rem_next       = '0;
                step_next      = '0;
                div_score_next = 1'b0;
            end
            ST_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                if (div_r >= {1'b0, den_reg})
                begin
                    rem_next = 16'(div_r - {1'b0, den_reg});
                    num_next = {num_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = div_r[15:0];
                    num_next = {num_reg[62:0], 1'b0};
                end
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd63)
                begin
                    step_next   = '0;
                    sq_v_next   = num_next;
                    sq_res_next = '0;
                    sq_bit_next = 64'd1 << 62;
                end
            end
            ST_ADDSUM:
            begin
                dev_next  = add_sat64(dev_reg, num_reg);
                last_next = (14'(idx_reg) + 14'd1 >= 14'(count_eff));
            end
            ST_SCORE:
            begin
                score_next = '0;
                if (last_reg && mode_reg)
                    score_next = (sc_round > 49'hFF_FFFF_FFFF) ? {40{1'b1}} : sc_round[39:0];
                num_next       = dev_reg;
                den_next       = 16'(count_eff);
                rem_next       = '0;
                step_next      = '0;
                div_score_next = 1'b1;
            end
            ST_SQRT:
            begin
                if (sq_v_reg >= sq_sum)
                begin
                    sq_v_next   = sq_v_reg - sq_sum;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_next = sq_res_reg >> 1;
                sq_bit_next = sq_bit_reg >> 2;
                step_next   = step_reg + 6'd1;
                if (step_reg == 6'd31)
                begin
                    step_next  = '0;
                    score_next = sq_res_next[39:0];
                end
            end
            ST_OUT:
                if (out_load)
                begin
                    if (last_reg)
                    begin
                        dev_next = '0;
                        idx_next = '0;
                    end
                    else
                        idx_next = idx_reg + 13'd1;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mode_reg   <= 1'b0;
            count_reg  <= 13'd1;
            offset_reg <= '0;
            length_reg <= 16'd1;
            dev_reg    <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
            step_reg   <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            for (int i = 0; i < 9; i++) rot_reg[i] <= '0;
            for (int i = 0; i < 3; i++) trn_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dev_reg   <= dev_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            if (cfg_wr)
            begin
                case (rtr_reg_t'(paddr[3:2]))
                    REG_MODE:   mode_reg   <= pwdata[0];
                    REG_COUNT:  count_reg  <= pwdata[CNT_W-1:0];
                    REG_OFFSET: offset_reg <= pwdata[15:0];
                    REG_LENGTH: length_reg <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (in_acc && in_ch.kind == KIND_ROW && in_ch.row_index != 2'd3)
            begin
                rot_reg[4'(in_ch.row_index) * 4'd3]        <= in_ch.row_coef_x;
                rot_reg[4'(in_ch.row_index) * 4'd3 + 4'd1] <= in_ch.row_coef_y;
                rot_reg[4'(in_ch.row_index) * 4'd3 + 4'd2] <= in_ch.row_coef_z;
                trn_reg[in_ch.row_index]                   <= in_ch.translation_part;
            end
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc && in_ch.kind == KIND_POINT)
        begin
            tg_reg[0] <= in_ch.target_x;
            tg_reg[1] <= in_ch.target_y;
            tg_reg[2] <= in_ch.target_z;
            pt_reg[0] <= in_ch.moved_x;
            pt_reg[1] <= in_ch.moved_y;
            pt_reg[2] <= in_ch.moved_z;
        end
        for (int i = 0; i < 3; i++) mv_reg[i] <= mv_next[i];
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        d2_reg        <= d2_next;
        last_reg      <= last_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        div_score_reg <= div_score_next;
        sq_v_reg      <= sq_v_next;
        sq_res_reg    <= sq_res_next;
        sq_bit_reg    <= sq_bit_next;
        score_reg     <= score_next;
        // hold the whole result while it waits on out_ch
        if (out_load)
        begin
            out_ch.out_x      <= mv_reg[0];
            out_ch.out_y      <= mv_reg[1];
            out_ch.out_z      <= mv_reg[2];
            out_ch.last_point <= last_reg;
            out_ch.score      <= score_reg;
        end
    end

endmodule

>>> tb/rigid_transform_rmsd_test.sv
// Self-checking testbench for rigid_transform_rmsd: row loads, point moves and scores.
// Predicts every moved point and group score in SV and checks them at the output channel.
// Depends on rtr_pkg, rtr_if.sv (rtr_in_if, rtr_out_if) and the block's RTL.
`timescale 1ns / 1ps

module rigid_transform_rmsd_test;
    import rtr_pkg::*;

    localparam int  CLK_HALF    = 6;
    localparam int  DRAIN_PAD   = 300;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam longint SAT_HI   = 64'sd2147483647;
    localparam longint SAT_LO   = -64'sd2147483648;

    typedef struct packed {
        logic               kind;
        logic [1:0]         row_index;
        logic signed [31:0] row_coef_x;
        logic signed [31:0] row_coef_y;
        logic signed [31:0] row_coef_z;
        logic signed [31:0] translation_part;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] moved_x;
        logic signed [31:0] moved_y;
        logic signed [31:0] moved_z;
    } xform_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               last_point;
        logic [39:0]        score;
    } moved_point_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rtr_in_if  in_ch ();
    rtr_out_if out_ch ();

    rigid_transform_rmsd u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    xform_item_t  pending_items[$];
    moved_point_t expected_points[$];
    int           send_idle_pct;
    int           recv_stall_pct;
    int           mismatches;
    longint       cycles;

    // predictor copy of the block's registers and state
    logic         cfg_mode;
    logic [12:0]  cfg_count;
    logic [15:0]  cfg_offset;
    logic [15:0]  cfg_length;
    longint       rot_coef[9];
    longint       trans_coef[3];
    logic [63:0]  dev_sum;
    logic [12:0]  pt_index;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    function automatic logic [63:0] sum_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic void reset_model();
        cfg_mode   = 1'b0;
        cfg_count  = 13'd1;
        cfg_offset = 16'd0;
        cfg_length = 16'd1;
        foreach (rot_coef[i]) rot_coef[i] = 0;
        foreach (trans_coef[i]) trans_coef[i] = 0;
        dev_sum  = '0;
        pt_index = '0;
    endfunction

    // Move the point, accumulate its deviation, and queue the expected result.
    function automatic void predict_transfer(input xform_item_t it);
        longint      src[3];
        longint      tgt[3];
        longint      mv[3];
        longint      q;
        longint      prod;
        longint      d;
        longint      cnt;
        longint      pos;
        longint      wgt;
        logic [63:0] rem;
        logic [63:0] mag;
        logic [63:0] d2;
        logic [63:0] s;
        logic        last;
        moved_point_t res;
        if (it.kind == KIND_ROW)
        begin
            if (it.row_index < 2'd3)
            begin
                rot_coef[it.row_index*3 + 0] = it.row_coef_x;
                rot_coef[it.row_index*3 + 1] = it.row_coef_y;
                rot_coef[it.row_index*3 + 2] = it.row_coef_z;
                trans_coef[it.row_index]      = it.translation_part;
            end
            return;
        end
        src[0] = it.moved_x;  src[1] = it.moved_y;  src[2] = it.moved_z;
        tgt[0] = it.target_x; tgt[1] = it.target_y; tgt[2] = it.target_z;
        d2 = '0;
        for (int r = 0; r < 3; r++)
        begin
            q   = 0;
            rem = '0;
            for (int c = 0; c < 3; c++)
            begin
                prod = rot_coef[r*3 + c] * src[c];
                q    = q + (prod >>> 30);
                rem  = rem + {34'd0, prod[29:0]};
            end
            q = q + longint'((rem + 64'd536870912) >> 30) + trans_coef[r];
            if (q > SAT_HI) q = SAT_HI;
            if (q < SAT_LO) q = SAT_LO;
            mv[r] = q;
            d   = tgt[r] - mv[r];
            mag = (d < 0) ? 64'(-d) : 64'(d);
            d2  = sum_sat(d2, mag * mag);
        end
        cnt = cfg_count;
        if (cnt < 1) cnt = 1;
        if (cnt > MAX_POINTS) cnt = MAX_POINTS;
        if (cfg_mode)
        begin
            pos = longint'(cfg_offset) + longint'(pt_index);
            wgt = (pos < cnt - 1) ? pos + 1 : cnt;
            if (pos > longint'(cfg_length) - cnt) wgt = longint'(cfg_length) - pos;
            if (wgt < 1) wgt = 1;
            d2 = d2 / 64'(wgt);
        end
        dev_sum = sum_sat(dev_sum, d2);
        last = (longint'(pt_index) + 1 >= cnt);
        res.out_x      = mv[0][31:0];
        res.out_y      = mv[1][31:0];
        res.out_z      = mv[2][31:0];
        res.last_point = last;
        res.score      = '0;
        if (last)
        begin
            if (cfg_mode)
            begin
                s = (dev_sum >> 16) + ((dev_sum >> 15) & 64'd1);
                if (s > 64'hFF_FFFF_FFFF) s = 64'hFF_FFFF_FFFF;
            end
            else
                s = int_sqrt(dev_sum / 64'(cnt));
            res.score = s[39:0];
            dev_sum   = '0;
            pt_index  = '0;
        end
        else
            pt_index = pt_index + 13'd1;
        expected_points.push_back(res);
    endfunction

    // input driver: hold the item until transfer, then advance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_ch.valid || in_ch.ready)
            begin
                if (in_ch.valid)
                    predict_transfer({in_ch.kind, in_ch.row_index, in_ch.row_coef_x,
                                      in_ch.row_coef_y, in_ch.row_coef_z,
                                      in_ch.translation_part, in_ch.target_x,
                                      in_ch.target_y, in_ch.target_z, in_ch.moved_x,
                                      in_ch.moved_y, in_ch.moved_z});
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    xform_item_t nx;
                    nx = pending_items.pop_front();
                    in_ch.valid            <= 1'b1;
                    in_ch.kind             <= nx.kind;
                    in_ch.row_index        <= nx.row_index;
                    in_ch.row_coef_x       <= nx.row_coef_x;
                    in_ch.row_coef_y       <= nx.row_coef_y;
                    in_ch.row_coef_z       <= nx.row_coef_z;
                    in_ch.translation_part <= nx.translation_part;
                    in_ch.target_x         <= nx.target_x;
                    in_ch.target_y         <= nx.target_y;
                    in_ch.target_z         <= nx.target_z;
                    in_ch.moved_x          <= nx.moved_x;
                    in_ch.moved_y          <= nx.moved_y;
                    in_ch.moved_z          <= nx.moved_z;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // output monitor and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                moved_point_t got;
                moved_point_t want;
                got = {out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.last_point,
                       out_ch.score};
                if (expected_points.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result x=%0d y=%0d z=%0d last=%0b score=%0h",
                                 got.out_x, got.out_y, got.out_z, got.last_point, got.score);
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got != want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: result mismatch exp x=%0d y=%0d z=%0d last=%0b ",
                                      "score=%0h got x=%0d y=%0d z=%0d last=%0b score=%0h"},
                                     want.out_x, want.out_y, want.out_z, want.last_point,
                                     want.score, got.out_x, got.out_y, got.out_z,
                                     got.last_point, got.score);
                    end
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic reg_write(input rtr_reg_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_MODE:   cfg_mode   = value[0];
            REG_COUNT:  cfg_count  = value[12:0];
            REG_OFFSET: cfg_offset = value[15:0];
            default:    cfg_length = value[15:0];
        endcase
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || in_ch.valid || expected_points.size() > 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom();
            default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_rot();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return 32'h4000_0000;
            2:       return 32'hC000_0000;
            default: return 32'($signed($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000);
        endcase
    endfunction

    function automatic xform_item_t row_item(input logic [1:0] row);
        xform_item_t it;
        it = '0;
        it.kind             = KIND_ROW;
        it.row_index        = row;
        it.row_coef_x       = pick_rot();
        it.row_coef_y       = pick_rot();
        it.row_coef_z       = pick_rot();
        it.translation_part = pick_coord();
        // unused point fields target_x and moved_z still toggle
        it.target_x = $urandom();
        it.moved_z  = $urandom();
        return it;
    endfunction

    function automatic xform_item_t point_item();
        xform_item_t it;
        it.kind             = KIND_POINT;
        it.row_index        = $urandom_range(0, 3);
        it.row_coef_x       = $urandom();
        it.row_coef_y       = $urandom();
        it.row_coef_z       = $urandom();
        it.translation_part = $urandom();
        it.target_x         = pick_coord();
        it.target_y         = pick_coord();
        it.target_z         = pick_coord();
        it.moved_x          = pick_coord();
        it.moved_y          = pick_coord();
        it.moved_z          = pick_coord();
        return it;
    endfunction

    function automatic xform_item_t fixed_row(input logic [1:0] row, input logic [31:0] c,
                                              input logic [31:0] t);
        xform_item_t it;
        it = '0;
        it.kind             = KIND_ROW;
        it.row_index        = row;
        it.row_coef_x       = c;
        it.row_coef_y       = c;
        it.row_coef_z       = c;
        it.translation_part = t;
        return it;
    endfunction

    function automatic xform_item_t fixed_point(input logic [31:0] tg, input logic [31:0] mv);
        xform_item_t it;
        it = '0;
        it.kind     = KIND_POINT;
        it.target_x = tg; it.target_y = tg; it.target_z = tg;
        it.moved_x  = mv; it.moved_y  = mv; it.moved_z  = mv;
        return it;
    endfunction

    initial
    begin
        int          quota;
        int          sent;
        int          npts;
        logic [1:0]  first_row;
        cycles         = 0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        in_ch.valid = 1'b0;
        {in_ch.kind, in_ch.row_index, in_ch.row_coef_x, in_ch.row_coef_y, in_ch.row_coef_z,
         in_ch.translation_part, in_ch.target_x, in_ch.target_y, in_ch.target_z,
         in_ch.moved_x, in_ch.moved_y, in_ch.moved_z} = '0;
        out_ch.ready = 1'b0;
        reset_model();
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero transform at reset, ignored row 3, saturation extremes
        pending_items.push_back(fixed_point(32'h7FFF_FFFF, 32'h8000_0000));
        pending_items.push_back(fixed_row(2'd3, 32'h4000_0000, 32'h0001_0000));
        pending_items.push_back(fixed_point(32'h8000_0000, 32'h7FFF_FFFF));
        pending_items.push_back(fixed_row(2'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_items.push_back(fixed_row(2'd1, 32'h8000_0000, 32'h8000_0000));
        pending_items.push_back(fixed_row(2'd2, 32'h4000_0000, 32'h0000_0000));
        pending_items.push_back(fixed_point(32'h8000_0000, 32'h7FFF_FFFF));
        pending_items.push_back(fixed_point(32'h7FFF_FFFF, 32'h8000_0000));
        pending_items.push_back(fixed_point(32'h0000_0000, 32'hFFFF_FFFF));
        wait_idle();
        // weighted mode, far edge of a maximum-length structure (weight clamps to one)
        reg_write(REG_MODE, 32'd1);
        reg_write(REG_COUNT, 32'd3);
        reg_write(REG_OFFSET, 32'd65535);
        reg_write(REG_LENGTH, 32'd65535);
        repeat (3) pending_items.push_back(fixed_point(32'h7FFF_FFFF, 32'h8000_0000));
        wait_idle();
        reg_write(REG_OFFSET, 32'd0);
        reg_write(REG_LENGTH, 32'd2);
        repeat (3) pending_items.push_back(point_item());
        wait_idle();
        // count above range, then lowered mid-group so the next point ends it
        reg_write(REG_MODE, 32'd0);
        reg_write(REG_COUNT, 32'd8191);
        repeat (4) pending_items.push_back(point_item());
        wait_idle();
        reg_write(REG_COUNT, 32'd2);
        pending_items.push_back(point_item());
        wait_idle();
        reg_write(REG_COUNT, 32'd0);
        repeat (2) pending_items.push_back(point_item());
        wait_idle();

        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            reg_write(REG_MODE, {31'd0, p[0]});
            case (p)
                0: reg_write(REG_COUNT, 32'd1);
                5: reg_write(REG_COUNT, 32'd4096);
                default: reg_write(REG_COUNT, $urandom_range(2, 12));
            endcase
            reg_write(REG_OFFSET, (p == 7) ? 32'd65535 : $urandom_range(0, 20));
            reg_write(REG_LENGTH, (p == 3) ? 32'd65535 : $urandom_range(1, 24));
            quota = 225;
            sent  = 0;
            while (sent < quota)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    first_row = $urandom_range(0, 2);
                    for (int r = 0; r < 3; r++)
                        pending_items.push_back(row_item(2'((first_row + r) % 3)));
                    if ($urandom_range(0, 4) == 0)
                        pending_items.push_back(row_item(2'd3));
                    sent += 3;
                end
                npts = $urandom_range(1, 12);
                repeat (npts) pending_items.push_back(point_item());
                sent += npts;
            end
            // let the output drain completely before moving on
            wait_idle();
        end

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
